/* src/aabb_narrow_phase_collision_top_defines.svh */
// Assertion macros used by the collision block's checker.
// Depends on nothing; the using module supplies clk and rst.
`ifndef AABB_NARROW_PHASE_COLLISION_TOP_DEFINES_SVH
`define AABB_NARROW_PHASE_COLLISION_TOP_DEFINES_SVH

// A property checked out of reset.
`define AABBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A property that must also hold through reset.
`define AABBC_ASSERT_RESET(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/aabbc_pkg.sv */
// Shared types, constants and arithmetic steps of the box collision block.
// Depends on nothing.
package aabbc_pkg;

  localparam int CW = 24;              // coordinate width
  localparam int EW = 22;              // extent and radius width
  localparam int NW = 16;              // normal width
  localparam int PW = 23;              // penetration width
  localparam int DW = CW + 2;          // doubled centre difference
  localparam int XW = EW + 1;          // doubled extent
  localparam int GW = DW + 1;          // face gap
  localparam int SQW = 48;             // square root radicand
  localparam int RTW = 24;             // square root result
  localparam int RMW = RTW + 3;        // square root remainder
  localparam int QW = 15;              // normal quotient
  localparam int DRW = RTW + 1;        // divider remainder
  localparam int SQ_STEPS = RTW;
  localparam int DIV_STEPS = QW;
  localparam int NP_DEPTH = SQ_STEPS + DIV_STEPS;

  localparam logic [1:0] CFG_BOX_WIDTH = 2'd0;
  localparam logic [1:0] CFG_BOX_HEIGHT = 2'd1;
  localparam logic [EW-1:0] EXT_RESET = EW'(256);
  localparam logic signed [NW-1:0] NORM_ONE = 16'sd16384;

  typedef enum logic [1:0] {FACE_RIGHT, FACE_LEFT, FACE_TOP, FACE_BOTTOM} face_t;

  typedef struct packed {
    logic                 action;
    logic signed [CW-1:0] self_x;
    logic signed [CW-1:0] self_y;
    logic signed [CW-1:0] other_x;
    logic signed [CW-1:0] other_y;
    logic [EW-1:0]        other_radius;
    logic [EW-1:0]        other_width;
    logic [EW-1:0]        other_height;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [NW-1:0] normal_x;
    logic signed [NW-1:0] normal_y;
    logic signed [CW-1:0] contact_x;
    logic signed [CW-1:0] contact_y;
    logic [PW-1:0]        penetration;
  } out_t;

  typedef struct packed {
    logic                 action;
    logic                 hit;
    logic signed [CW-1:0] contact_x;
    logic signed [CW-1:0] contact_y;
    logic [PW-1:0]        pen_box;
    face_t                face;
    logic                 sgn_x;
    logic                 sgn_y;
    logic [EW-1:0]        abs_x;
    logic [EW-1:0]        abs_y;
    logic [XW-1:0]        r2;
  } side_t;

  typedef struct packed {
    logic [SQW-1:0] rad;
    logic [RMW-1:0] rem;
    logic [RTW-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [DRW-1:0] rem;
    logic [QW-1:0]  q;
  } dv_t;

  typedef struct packed {
    side_t side;
    sq_t   sd;
    sq_t   sm;
    dv_t   qx;
    dv_t   qy;
  } np_t;

  // One result bit of a restoring integer square root.
  function automatic sq_t sq_step(sq_t a);
    logic [RMW-1:0] sh;
    logic [RMW-1:0] trial;
    sq_t r;
    sh = {a.rem[RMW-3:0], a.rad[SQW-1 -: 2]};
    trial = {1'b0, a.root, 2'b01};
    r.rad = {a.rad[SQW-3:0], 2'b00};
    if (sh >= trial) begin
      r.rem = sh - trial;
      r.root = {a.root[RTW-2:0], 1'b1};
    end else begin
      r.rem = sh;
      r.root = {a.root[RTW-2:0], 1'b0};
    end
    return r;
  endfunction

  // One quotient bit of a restoring division by mag.
  function automatic dv_t dv_step(dv_t a, logic [RTW-1:0] mag);
    logic [DRW-1:0] m;
    logic [DRW-1:0] t;
    logic ge;
    dv_t r;
    m = {1'b0, mag};
    ge = (a.rem >= m);
    t = ge ? a.rem - m : a.rem;
    r.rem = {t[DRW-2:0], 1'b0};
    r.q = {a.q[QW-2:0], ge};
    return r;
  endfunction

  // Halve a doubled coordinate by floor and saturate it to the coordinate range.
  function automatic logic [CW-1:0] sat_half(logic [DW-1:0] v);
    logic [DW-2:0] h;
    h = v[DW-1:1];
    if (h[CW] != h[CW-1]) begin
      return h[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    return h[CW-1:0];
  endfunction

  // Halve a doubled gap and saturate it to the penetration range.
  function automatic logic [PW-1:0] sat_pen(logic [GW-1:0] g);
    logic [GW-2:0] h;
    h = g[GW-1:1];
    if (|h[GW-2:PW]) begin
      return {PW{1'b1}};
    end
    return h[PW-1:0];
  endfunction

  function automatic logic [GW-1:0] abs_gap(logic signed [GW-1:0] g);
    return g[GW-1] ? -g : g;
  endfunction

endpackage

/* src/aabb_narrow_phase_collision_top.sv */
// Top level of the box narrow-phase collision block: front stages, root and
// divider pipeline (aabbc_norm_pipe) and output register. Uses aabbc_pkg.
//
// One collision test is accepted per clock cycle while the pipeline is not
// stalled. Each passes through four front stages (offset and clamp, gaps and
// contact, squares, sums and face choice), 24 stages of the bit-per-stage
// square root, 15 stages of the bit-per-stage normal divider and the output
// register. Every stage holds its item until the next one can take it, so
// back-pressure on the result side only stalls as far back as the pipeline
// is full. Box width and height must be written through the configuration
// port only while no test is in flight; the block does not enforce this.
module aabb_narrow_phase_collision_top import aabbc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_t           in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output out_t          out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [EW-1:0] cfg_data
);

  typedef struct packed {
    logic                 action;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [XW-1:0] cx;
    logic signed [XW-1:0] cy;
    logic [XW-1:0]        r2;
    logic [XW-1:0]        sw;
    logic [XW-1:0]        sh;
  } f1_t;

  typedef struct packed {
    logic                 action;
    logic signed [CW-1:0] cnt_x;
    logic signed [CW-1:0] cnt_y;
    logic [GW-1:0]        ex;
    logic [GW-1:0]        ey;
    logic [EW-1:0]        ax;
    logic [EW-1:0]        ay;
    logic                 sgn_x;
    logic                 sgn_y;
    logic [XW-1:0]        r2;
    logic signed [GW-1:0] g_r;
    logic signed [GW-1:0] g_l;
    logic signed [GW-1:0] g_t;
    logic signed [GW-1:0] g_b;
  } f2_t;

  typedef struct packed {
    logic                 action;
    logic                 pre_miss;
    logic                 ovl;
    logic signed [CW-1:0] cnt_x;
    logic signed [CW-1:0] cnt_y;
    logic [2*XW-1:0]      ex2;
    logic [2*XW-1:0]      ey2;
    logic [2*XW-1:0]      rr;
    logic [2*EW-1:0]      ax2;
    logic [2*EW-1:0]      ay2;
    logic [EW-1:0]        ax;
    logic [EW-1:0]        ay;
    logic                 sgn_x;
    logic                 sgn_y;
    logic [XW-1:0]        r2;
    logic [GW-1:0]        b01;
    logic [GW-1:0]        b23;
    face_t                f01;
    face_t                f23;
  } f3_t;

  logic [EW-1:0] box_width;
  logic [EW-1:0] box_height;

  f1_t f1, f1_next;
  f2_t f2, f2_next;
  f3_t f3, f3_next;
  np_t f4, f4_next;
  out_t o, o_next;
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy_o;
  logic np_in_ready, np_out_valid;
  np_t  np_out;

  // Configuration.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_width <= EXT_RESET;
      box_height <= EXT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BOX_WIDTH:  box_width <= cfg_data;
        CFG_BOX_HEIGHT: box_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake chain.
  assign rdy_o = !out_valid || out_ready;
  assign rdy4 = !v4 || np_in_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  // Stage 1: doubled centre offset clamped to the half extents.
  always_comb begin
    logic signed [CW:0]   dxh;
    logic signed [CW:0]   dyh;
    logic signed [DW-1:0] dxd;
    logic signed [DW-1:0] dyd;
    logic signed [DW-1:0] wx;
    logic signed [DW-1:0] hy;
    logic signed [DW-1:0] cxf;
    logic signed [DW-1:0] cyf;
    dxh = $signed({in_data.other_x[CW-1], in_data.other_x})
        - $signed({in_data.self_x[CW-1], in_data.self_x});
    dyh = $signed({in_data.other_y[CW-1], in_data.other_y})
        - $signed({in_data.self_y[CW-1], in_data.self_y});
    dxd = $signed({dxh, 1'b0});
    dyd = $signed({dyh, 1'b0});
    wx = $signed({{(DW-EW){1'b0}}, box_width});
    hy = $signed({{(DW-EW){1'b0}}, box_height});
    if (dxd > wx) cxf = wx;
    else if (dxd < -wx) cxf = -wx;
    else cxf = dxd;
    if (dyd > hy) cyf = hy;
    else if (dyd < -hy) cyf = -hy;
    else cyf = dyd;
    f1_next.action = in_data.action;
    f1_next.sx = in_data.self_x;
    f1_next.sy = in_data.self_y;
    f1_next.dx = dxd;
    f1_next.dy = dyd;
    f1_next.cx = cxf[XW-1:0];
    f1_next.cy = cyf[XW-1:0];
    f1_next.r2 = {in_data.other_radius, 1'b0};
    f1_next.sw = {1'b0, box_width} + {1'b0, in_data.other_width};
    f1_next.sh = {1'b0, box_height} + {1'b0, in_data.other_height};
  end

  // Stage 2: distance to the closest point, contact point and face gaps.
  always_comb begin
    logic signed [GW-1:0] cxe;
    logic signed [GW-1:0] cye;
    logic signed [GW-1:0] dxe;
    logic signed [GW-1:0] dye;
    logic signed [GW-1:0] dfx;
    logic signed [GW-1:0] dfy;
    logic signed [GW-1:0] swe;
    logic signed [GW-1:0] she;
    logic signed [DW-1:0] sumx;
    logic signed [DW-1:0] sumy;
    logic [XW-1:0]        axf;
    logic [XW-1:0]        ayf;
    cxe = $signed({{(GW-XW){f1.cx[XW-1]}}, f1.cx});
    cye = $signed({{(GW-XW){f1.cy[XW-1]}}, f1.cy});
    dxe = $signed({f1.dx[DW-1], f1.dx});
    dye = $signed({f1.dy[DW-1], f1.dy});
    dfx = cxe - dxe;
    dfy = cye - dye;
    swe = $signed({{(GW-XW){1'b0}}, f1.sw});
    she = $signed({{(GW-XW){1'b0}}, f1.sh});
    sumx = $signed({f1.sx[CW-1], f1.sx, 1'b0}) + $signed({{(DW-XW){f1.cx[XW-1]}}, f1.cx});
    sumy = $signed({f1.sy[CW-1], f1.sy, 1'b0}) + $signed({{(DW-XW){f1.cy[XW-1]}}, f1.cy});
    axf = f1.cx[XW-1] ? -f1.cx : f1.cx;
    ayf = f1.cy[XW-1] ? -f1.cy : f1.cy;
    f2_next.action = f1.action;
    f2_next.cnt_x = sat_half(sumx);
    f2_next.cnt_y = sat_half(sumy);
    f2_next.ex = abs_gap(dfx);
    f2_next.ey = abs_gap(dfy);
    f2_next.ax = axf[EW-1:0];
    f2_next.ay = ayf[EW-1:0];
    f2_next.sgn_x = f1.cx[XW-1];
    f2_next.sgn_y = f1.cy[XW-1];
    f2_next.r2 = f1.r2;
    f2_next.g_r = swe - dxe;
    f2_next.g_l = -dxe - swe;
    f2_next.g_t = she - dye;
    f2_next.g_b = -dye - she;
  end

  // Stage 3: squares, overlap test and first round of the gap minimum.
  always_comb begin
    logic [GW-1:0] a0, a1, a2, a3;
    logic [XW-1:0] exs, eys;
    a0 = abs_gap(f2.g_r);
    a1 = abs_gap(f2.g_l);
    a2 = abs_gap(f2.g_t);
    a3 = abs_gap(f2.g_b);
    exs = f2.ex[XW-1:0];
    eys = f2.ey[XW-1:0];
    f3_next.action = f2.action;
    f3_next.pre_miss = (f2.ex > {{(GW-XW){1'b0}}, f2.r2})
                    || (f2.ey > {{(GW-XW){1'b0}}, f2.r2});
    f3_next.ovl = (!f2.g_r[GW-1] && f2.g_r != '0) && f2.g_l[GW-1]
               && (!f2.g_t[GW-1] && f2.g_t != '0) && f2.g_b[GW-1];
    f3_next.cnt_x = f2.cnt_x;
    f3_next.cnt_y = f2.cnt_y;
    f3_next.ex2 = exs * exs;
    f3_next.ey2 = eys * eys;
    f3_next.rr = f2.r2 * f2.r2;
    f3_next.ax2 = f2.ax * f2.ax;
    f3_next.ay2 = f2.ay * f2.ay;
    f3_next.ax = f2.ax;
    f3_next.ay = f2.ay;
    f3_next.sgn_x = f2.sgn_x;
    f3_next.sgn_y = f2.sgn_y;
    f3_next.r2 = f2.r2;
    // On equal gaps the face listed earlier keeps the win.
    if (a1 < a0) begin
      f3_next.b01 = a1;
      f3_next.f01 = FACE_LEFT;
    end else begin
      f3_next.b01 = a0;
      f3_next.f01 = FACE_RIGHT;
    end
    if (a3 < a2) begin
      f3_next.b23 = a3;
      f3_next.f23 = FACE_BOTTOM;
    end else begin
      f3_next.b23 = a2;
      f3_next.f23 = FACE_TOP;
    end
  end

  // Stage 4: squared distances, hit decision and the winning face.
  always_comb begin
    logic [2*XW:0]   d2;
    logic [2*EW:0]   m2;
    logic            hitc;
    logic [GW-1:0]   best;
    face_t           face;
    d2 = {1'b0, f3.ex2} + {1'b0, f3.ey2};
    m2 = {1'b0, f3.ax2} + {1'b0, f3.ay2};
    hitc = !f3.pre_miss && (d2 <= {1'b0, f3.rr});
    if (f3.b23 < f3.b01) begin
      best = f3.b23;
      face = f3.f23;
    end else begin
      best = f3.b01;
      face = f3.f01;
    end
    f4_next.side.action = f3.action;
    f4_next.side.hit = f3.action ? f3.ovl : hitc;
    f4_next.side.contact_x = f3.cnt_x;
    f4_next.side.contact_y = f3.cnt_y;
    f4_next.side.pen_box = sat_pen(best);
    f4_next.side.face = face;
    f4_next.side.sgn_x = f3.sgn_x;
    f4_next.side.sgn_y = f3.sgn_y;
    f4_next.side.abs_x = f3.ax;
    f4_next.side.abs_y = f3.ay;
    f4_next.side.r2 = f3.r2;
    f4_next.sd.rad = SQW'(d2);
    f4_next.sd.rem = '0;
    f4_next.sd.root = '0;
    f4_next.sm.rad = SQW'(m2);
    f4_next.sm.rem = '0;
    f4_next.sm.root = '0;
    f4_next.qx = '0;
    f4_next.qy = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) f1 <= f1_next;
    if (rdy2 && v1) f2 <= f2_next;
    if (rdy3 && v2) f3 <= f3_next;
    if (rdy4 && v3) f4 <= f4_next;
  end

  aabbc_norm_pipe u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_ready  (np_in_ready),
    .in_data   (f4),
    .out_valid (np_out_valid),
    .out_ready (rdy_o),
    .out_data  (np_out)
  );

  // Output stage: normals and penetration for the chosen test.
  always_comb begin
    logic signed [NW-1:0] qx;
    logic signed [NW-1:0] qy;
    logic signed [RTW:0]  pdiff;
    qx = $signed({1'b0, np_out.qx.q});
    qy = $signed({1'b0, np_out.qy.q});
    pdiff = $signed({2'b00, np_out.side.r2}) - $signed({1'b0, np_out.sd.root});
    o_next = '0;
    if (np_out.side.hit) begin
      o_next.hit = 1'b1;
      o_next.contact_x = np_out.side.contact_x;
      o_next.contact_y = np_out.side.contact_y;
      if (np_out.side.action) begin
        o_next.penetration = np_out.side.pen_box;
        case (np_out.side.face)
          FACE_RIGHT:  o_next.normal_x = NORM_ONE;
          FACE_LEFT:   o_next.normal_x = -NORM_ONE;
          FACE_TOP:    o_next.normal_y = NORM_ONE;
          default:     o_next.normal_y = -NORM_ONE;
        endcase
      end else begin
        o_next.penetration = pdiff[RTW] ? '0 : pdiff[PW:1];
        // A zero offset has no direction and leaves the normal at zero.
        if (np_out.sm.root != '0) begin
          o_next.normal_x = np_out.side.sgn_x ? -qx : qx;
          o_next.normal_y = np_out.side.sgn_y ? -qy : qy;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_o) begin
      out_valid <= np_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && np_out_valid) o <= o_next;
  end

  assign out_data = o;

endmodule

/* src/aabbc_norm_pipe.sv */
// Pipelined square roots of the distance and offset magnitude, then the
// divisions that normalise the offset. Depends on aabbc_pkg.
module aabbc_norm_pipe import aabbc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  np_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output np_t  out_data
);

  np_t st [NP_DEPTH];
  logic [NP_DEPTH-1:0] v;
  logic [NP_DEPTH-1:0] rdy;

  for (genvar i = 0; i < NP_DEPTH; i++) begin : g_stage
    np_t  prev;
    np_t  nxt;
    logic prev_v;
    logic nxt_rdy;

    if (i == 0) begin : g_first
      assign prev = in_data;
      assign prev_v = in_valid;
    end else begin : g_mid
      assign prev = st[i-1];
      assign prev_v = v[i-1];
    end

    if (i == NP_DEPTH - 1) begin : g_last
      assign nxt_rdy = out_ready;
    end else begin : g_inner
      assign nxt_rdy = rdy[i+1];
    end

    assign rdy[i] = !v[i] || nxt_rdy;

    if (i < SQ_STEPS) begin : g_sqrt
      always_comb begin
        nxt = prev;
        nxt.sd = sq_step(prev.sd);
        nxt.sm = sq_step(prev.sm);
        // The last root stage loads the dividers with the clamped offset.
        if (i == SQ_STEPS - 1) begin
          nxt.qx.rem = DRW'(prev.side.abs_x);
          nxt.qx.q = '0;
          nxt.qy.rem = DRW'(prev.side.abs_y);
          nxt.qy.q = '0;
        end
      end
    end else begin : g_div
      always_comb begin
        nxt = prev;
        nxt.qx = dv_step(prev.qx, prev.sm.root);
        nxt.qy = dv_step(prev.qy, prev.sm.root);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && prev_v) begin
        st[i] <= nxt;
      end
    end
  end

  assign in_ready = rdy[0];
  assign out_valid = v[NP_DEPTH-1];
  assign out_data = st[NP_DEPTH-1];

endmodule

/* src/aabbc_checker.sv */
// Port-level checks of the box collision block, bound to its top level.
// Depends on aabbc_pkg and the assertion macro header.
`include "aabb_narrow_phase_collision_top_defines.svh"

module aabbc_checker import aabbc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  `AABBC_ASSERT_ALWAYS(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
  `AABBC_ASSERT_ALWAYS(a_miss_zero, out_valid && !out_data.hit |-> out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.contact_x == '0 && out_data.contact_y == '0 && out_data.penetration == '0, "miss item carries non-zero fields")
  `AABBC_ASSERT_ALWAYS(a_norm_range, out_valid && out_data.hit |-> out_data.normal_x <= NORM_ONE && out_data.normal_x >= -NORM_ONE && out_data.normal_y <= NORM_ONE && out_data.normal_y >= -NORM_ONE, "normal outside unit range")
  `AABBC_ASSERT_RESET(a_reset_empty, rst |=> !out_valid, "result valid after reset")

endmodule

bind aabb_narrow_phase_collision_top aabbc_checker u_aabbc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
